>>> hw/rtl/timestamped_buffer_queue_assert.svh
// ----------------------------------------------------------------------------
// Timestamped buffer queue assertion macros
// Concurrent assertion shorthands shared by the queue's checker.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_BUFFER_QUEUE_ASSERT_SVH
`define TIMESTAMPED_BUFFER_QUEUE_ASSERT_SVH

// same-cycle implication
`define TBQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timestamped_buffer_queue: assertion failed");

// next-cycle implication
`define TBQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timestamped_buffer_queue: assertion failed");

`endif

>>> hw/rtl/tbq_pkg.sv
// ----------------------------------------------------------------------------
// Timestamped buffer queue package
// Widths, request and error codes and the ring entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package tbq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int HANDLE_W = 16;
    localparam int STAMP_W  = 32;
    localparam int BYTES_W  = 24;
    localparam int TOTAL_W  = 30;
    localparam int SPAN_W   = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_CLEAR = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [STAMP_W-1:0]  stamp;
        logic [BYTES_W-1:0]  size;
        logic                in_order;
    } entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/tbq_if.sv
// ----------------------------------------------------------------------------
// Timestamped buffer queue channels
// Valid/ready request and response channels of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbq_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         req_type;
    logic [tbq_pkg::HANDLE_W-1:0]       buf_handle;
    logic signed [tbq_pkg::STAMP_W-1:0] buf_timestamp;
    logic [tbq_pkg::BYTES_W-1:0]        buf_bytes;

    modport source (
        output valid, req_type, buf_handle, buf_timestamp, buf_bytes,
        input  ready
    );
    modport sink (
        input  valid, req_type, buf_handle, buf_timestamp, buf_bytes,
        output ready
    );
endinterface

interface tbq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               pop_valid;
    logic [tbq_pkg::HANDLE_W-1:0]       out_handle;
    logic signed [tbq_pkg::STAMP_W-1:0] out_timestamp;
    logic [tbq_pkg::BYTES_W-1:0]        out_bytes;
    logic                               queue_empty;
    logic [tbq_pkg::TOTAL_W-1:0]        total_bytes;
    logic [tbq_pkg::SPAN_W-1:0]         span_duration;
    logic [1:0]                         error_code;

    modport source (
        output valid, pop_valid, out_handle, out_timestamp, out_bytes,
               queue_empty, total_bytes, span_duration, error_code,
        input  ready
    );
    modport sink (
        input  valid, pop_valid, out_handle, out_timestamp, out_bytes,
               queue_empty, total_bytes, span_duration, error_code,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/tbq_entry_ram.sv
// ----------------------------------------------------------------------------
// Entry ring memory
// Descriptor ring, one write port and one registered read port with
// write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module tbq_entry_ram #(
    parameter int DEPTH  = tbq_pkg::QUEUE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  tbq_pkg::entry_t        wr_data,
    input  logic [ADDR_W-1:0]      rd_addr,
    output tbq_pkg::entry_t        rd_data
);

    tbq_pkg::entry_t mem [DEPTH];
    tbq_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tbq_stamp_ram.sv
// ----------------------------------------------------------------------------
// In-order timestamp ring memory
// Side ring, one write port and two registered read ports with
// write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module tbq_stamp_ram #(
    parameter int DEPTH  = tbq_pkg::QUEUE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [tbq_pkg::STAMP_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0]            rd_addr0,
    input  logic [ADDR_W-1:0]            rd_addr1,
    output logic [tbq_pkg::STAMP_W-1:0]  rd_data0,
    output logic [tbq_pkg::STAMP_W-1:0]  rd_data1
);

    logic [tbq_pkg::STAMP_W-1:0] mem [DEPTH];
    logic [tbq_pkg::STAMP_W-1:0] rd0_reg;
    logic [tbq_pkg::STAMP_W-1:0] rd1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr0))
        begin
            rd0_reg <= wr_data;
        end
        else
        begin
            rd0_reg <= mem[rd_addr0];
        end
        if (wr_en && (wr_addr == rd_addr1))
        begin
            rd1_reg <= wr_data;
        end
        else
        begin
            rd1_reg <= mem[rd_addr1];
        end
    end

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;

endmodule

`default_nettype wire

>>> hw/rtl/timestamped_buffer_queue.sv
// ----------------------------------------------------------------------------
// Timestamped buffer queue
// FIFO of buffer descriptors with byte total and in-order timestamp span.
// ----------------------------------------------------------------------------
// Takes one push, pop or clear request per cycle and returns exactly one
// response per request from an output register, in the cycle after the request
// beat; the request side keeps accepting while a response waits, as long as
// that response is taken in the same cycle. The rate of one request a cycle
// is set by the combinational update of the pointers and counters together
// with the prefetched head registers: the descriptor ring keeps its head
// entry, and the timestamp ring its first two in-order stamps, read ahead
// into registers. The rings are not cleared at reset and need no clearing
// pass; only written entries are ever used.
`default_nettype none

module timestamped_buffer_queue #(
    parameter int QUEUE_DEPTH = tbq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tbq_req_if.sink     req,
    tbq_rsp_if.source   rsp
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W = tbq_pkg::BYTES_W + CNT_W;
    localparam int CMP_W = (TOT_W > tbq_pkg::TOTAL_W) ? TOT_W : tbq_pkg::TOTAL_W;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    logic [PTR_W-1:0]             head_reg,   head_next;
    logic [PTR_W-1:0]             tail_reg,   tail_next;
    logic [CNT_W-1:0]             count_reg,  count_next;
    logic [PTR_W-1:0]             ohead_reg,  ohead_next;
    logic [PTR_W-1:0]             otail_reg,  otail_next;
    logic [CNT_W-1:0]             ocount_reg, ocount_next;
    logic [TOT_W-1:0]             total_reg,  total_next;
    logic [tbq_pkg::STAMP_W-1:0]  last_reg,   last_next;
    logic                         have_reg,   have_next;

    logic                           rsp_valid_reg, rsp_valid_next;
    logic                           pop_valid_reg, pop_valid_next;
    logic [tbq_pkg::HANDLE_W-1:0]   handle_reg,    handle_next;
    logic [tbq_pkg::STAMP_W-1:0]    stamp_reg,     stamp_next;
    logic [tbq_pkg::BYTES_W-1:0]    bytes_reg,     bytes_next;
    logic                           empty_reg,     empty_next;
    logic [tbq_pkg::TOTAL_W-1:0]    total_out_reg, total_out_next;
    logic [tbq_pkg::SPAN_W-1:0]     span_reg,      span_next;
    tbq_pkg::err_t                  err_reg,       err_next;

    logic                         accept;
    logic [tbq_pkg::STAMP_W-1:0]  ts_u;
    logic                         in_order;
    logic                         pop_side;
    logic                         e_wr;
    logic                         s_wr;
    tbq_pkg::entry_t              e_wr_data;
    tbq_pkg::entry_t              head_entry;
    logic [tbq_pkg::STAMP_W-1:0]  ofront0;
    logic [tbq_pkg::STAMP_W-1:0]  ofront1;
    logic [tbq_pkg::STAMP_W-1:0]  front;
    logic [TOT_W-1:0]             pop_size;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign ts_u      = req.buf_timestamp;
    assign in_order  = !ts_u[tbq_pkg::STAMP_W-1] && (!have_reg || (ts_u >= last_reg));
    assign pop_size  = TOT_W'(head_entry.size);

    assign e_wr_data = '{handle:   req.buf_handle,
                         stamp:    ts_u,
                         size:     req.buf_bytes,
                         in_order: in_order};

    tbq_entry_ram #(
        .DEPTH   (QUEUE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (e_wr),
        .wr_addr (tail_reg),
        .wr_data (e_wr_data),
        .rd_addr (head_next),
        .rd_data (head_entry)
    );

    tbq_stamp_ram #(
        .DEPTH    (QUEUE_DEPTH)
    ) u_stamp_ram (
        .clk      (clk),
        .wr_en    (s_wr),
        .wr_addr  (otail_reg),
        .wr_data  (ts_u),
        .rd_addr0 (ohead_next),
        .rd_addr1 (ptr_inc(ohead_next)),
        .rd_data0 (ofront0),
        .rd_data1 (ofront1)
    );

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        ohead_next     = ohead_reg;
        otail_next     = otail_reg;
        ocount_next    = ocount_reg;
        total_next     = total_reg;
        last_next      = last_reg;
        have_next      = have_reg;
        e_wr           = 1'b0;
        s_wr           = 1'b0;
        pop_side       = 1'b0;
        pop_valid_next = 1'b0;
        handle_next    = '0;
        stamp_next     = '0;
        bytes_next     = '0;
        err_next       = tbq_pkg::ERR_OK;

        if (accept)
        begin
            case (req.req_type)
                tbq_pkg::REQ_PUSH:
                begin
                    if (count_reg == FULL_CNT)
                    begin
                        err_next = tbq_pkg::ERR_FULL;
                    end
                    else
                    begin
                        e_wr       = 1'b1;
                        tail_next  = ptr_inc(tail_reg);
                        count_next = count_reg + 1'b1;
                        total_next = total_reg + TOT_W'(req.buf_bytes);
                        if (in_order)
                        begin
                            s_wr        = 1'b1;
                            otail_next  = ptr_inc(otail_reg);
                            ocount_next = ocount_reg + 1'b1;
                            last_next   = ts_u;
                            have_next   = 1'b1;
                        end
                    end
                end
                tbq_pkg::REQ_POP:
                begin
                    if (count_reg == '0)
                    begin
                        err_next = tbq_pkg::ERR_EMPTY;
                    end
                    else
                    begin
                        pop_valid_next = 1'b1;
                        handle_next    = head_entry.handle;
                        stamp_next     = head_entry.stamp;
                        bytes_next     = head_entry.size;
                        head_next      = ptr_inc(head_reg);
                        count_next     = count_reg - 1'b1;
                        total_next     = (total_reg >= pop_size) ? total_reg - pop_size : '0;
                        if (head_entry.in_order && (ocount_reg != '0))
                        begin
                            pop_side    = 1'b1;
                            ohead_next  = ptr_inc(ohead_reg);
                            ocount_next = ocount_reg - 1'b1;
                        end
                    end
                end
                tbq_pkg::REQ_CLEAR:
                begin
                    head_next   = '0;
                    tail_next   = '0;
                    count_next  = '0;
                    ohead_next  = '0;
                    otail_next  = '0;
                    ocount_next = '0;
                    total_next  = '0;
                    last_next   = '0;
                    have_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        // newest in-order stamp is always the back of the side ring while it holds entries
        front     = pop_side ? ofront1 : ofront0;
        span_next = (ocount_next >= CNT_W'(2)) ? last_next - front : '0;

        empty_next     = (count_next == '0);
        total_out_next = (CMP_W'(total_next) > CMP_W'(tbq_pkg::TOTAL_MAX))
                         ? tbq_pkg::TOTAL_MAX : tbq_pkg::TOTAL_W'(total_next);

        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            ohead_reg     <= '0;
            otail_reg     <= '0;
            ocount_reg    <= '0;
            total_reg     <= '0;
            last_reg      <= '0;
            have_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            ohead_reg     <= ohead_next;
            otail_reg     <= otail_next;
            ocount_reg    <= ocount_next;
            total_reg     <= total_next;
            last_reg      <= last_next;
            have_reg      <= have_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_valid_reg <= pop_valid_next;
            handle_reg    <= handle_next;
            stamp_reg     <= stamp_next;
            bytes_reg     <= bytes_next;
            empty_reg     <= empty_next;
            total_out_reg <= total_out_next;
            span_reg      <= span_next;
            err_reg       <= err_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.pop_valid     = pop_valid_reg;
    assign rsp.out_handle    = handle_reg;
    assign rsp.out_timestamp = stamp_reg;
    assign rsp.out_bytes     = bytes_reg;
    assign rsp.queue_empty   = empty_reg;
    assign rsp.total_bytes   = total_out_reg;
    assign rsp.span_duration = span_reg;
    assign rsp.error_code    = err_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tbq_checker.sv
// ----------------------------------------------------------------------------
// Timestamped buffer queue checker
// Port-level assertions, bound to the queue's top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timestamped_buffer_queue_assert.svh"

module tbq_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic [1:0]                    req_type,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic                          pop_valid,
    input wire logic                          queue_empty,
    input wire logic [tbq_pkg::TOTAL_W-1:0]   total_bytes,
    input wire logic [tbq_pkg::SPAN_W-1:0]    span_duration,
    input wire logic [1:0]                    error_code
);

    `TBQ_ASSERT_NEXT(a_beat_gives_rsp, req_valid && req_ready, rsp_valid)

    `TBQ_ASSERT_NEXT(a_clear_empties,
        req_valid && req_ready && (req_type == tbq_pkg::REQ_CLEAR),
        rsp_valid && queue_empty && (total_bytes == '0) && (span_duration == '0))

    `TBQ_ASSERT_NOW(a_empty_pop_flags,
        rsp_valid && (error_code == tbq_pkg::ERR_EMPTY),
        !pop_valid && queue_empty && (total_bytes == '0) && (span_duration == '0))

    `TBQ_ASSERT_NOW(a_span_needs_entries, rsp_valid && (span_duration != '0), !queue_empty)

    `TBQ_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind timestamped_buffer_queue tbq_checker u_tbq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_type      (req.req_type),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .pop_valid     (rsp.pop_valid),
    .queue_empty   (rsp.queue_empty),
    .total_bytes   (rsp.total_bytes),
    .span_duration (rsp.span_duration),
    .error_code    (rsp.error_code)
);

`default_nettype wire
